>>> rtl/rss_pkg.sv
// shared types and codes for the reduce-scatter step schedule block
package rss_pkg;

  localparam int unsigned MAX_RANKS  = 128;
  localparam int unsigned IDX_W      = 7;
  localparam int unsigned CNT_W      = 8;
  localparam int unsigned STEP_W     = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_RANK_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MY_INDEX   = 2'd1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_STEP  = 2'd1;
  localparam logic [1:0] ST_BAD_INDEX = 2'd2;

  // one classified step, ready for the slice walk
  typedef struct packed {
    logic [IDX_W-1:0] send_to;
    logic [IDX_W-1:0] recv_from;
    logic [IDX_W-1:0] tx_start;
    logic [IDX_W-1:0] rx_start;
    logic [IDX_W-1:0] stride;
    logic [IDX_W-1:0] count;
    logic [CNT_W-1:0] ranks;
    logic [1:0]       status;
  } cmd_t;

endpackage

>>> rtl/rss_front.sv
// front end: config registers, step classification and partner arithmetic
module rss_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rss_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rss_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [rss_pkg::STEP_W-1:0]         in_step,
  input  logic                               q_full,
  output logic                               q_push,
  output rss_pkg::cmd_t                      q_cmd
);

  logic [rss_pkg::CNT_W-1:0] rank_count_r;
  logic [rss_pkg::IDX_W-1:0] my_index_r;

  logic [rss_pkg::CNT_W-1:0] n;
  logic [rss_pkg::CNT_W-1:0] me;
  logic [rss_pkg::CNT_W-1:0] delta;
  logic [rss_pkg::CNT_W-1:0] from_sum;
  logic [rss_pkg::CNT_W-1:0] to_val;
  logic [rss_pkg::CNT_W-1:0] from_val;
  logic [rss_pkg::CNT_W:0]   pow2;
  logic [rss_pkg::CNT_W:0]   stride_val;
  logic [rss_pkg::CNT_W-1:0] span;
  logic [rss_pkg::CNT_W-1:0] count_val;
  logic [3:0]                shamt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rank_count_r <= 8'd1;
      my_index_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rss_pkg::CFG_RANK_COUNT: rank_count_r <= cfg_data;
        rss_pkg::CFG_MY_INDEX:   my_index_r   <= cfg_data[rss_pkg::IDX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    n        = (rank_count_r > rss_pkg::CNT_W'(rss_pkg::MAX_RANKS))
               ? rss_pkg::CNT_W'(rss_pkg::MAX_RANKS) : rank_count_r;
    me       = {1'b0, my_index_r};
    delta    = rss_pkg::CNT_W'(1) << in_step;
    shamt    = {1'b0, in_step} + 4'd1;
    to_val   = (me >= delta) ? (me - delta) : (me + n - delta);
    from_sum = me + delta;
    from_val = (from_sum >= n) ? (from_sum - n) : from_sum;
    pow2     = (rss_pkg::CNT_W+1)'(1) << shamt;
    stride_val = (pow2 >= {1'b0, n}) ? (pow2 - {1'b0, n}) : pow2;
    span     = n - 8'd1 + delta;
    count_val = span >> shamt;

    q_cmd = '0;
    if (me >= n) begin
      q_cmd.status = rss_pkg::ST_BAD_INDEX;
      q_cmd.count  = 7'd1;
    end else if (delta >= n) begin
      // step at or past ceil(log2 n), covers the single-rank ring too
      q_cmd.status = rss_pkg::ST_BAD_STEP;
      q_cmd.count  = 7'd1;
    end else begin
      q_cmd.status    = rss_pkg::ST_OK;
      q_cmd.send_to   = to_val[rss_pkg::IDX_W-1:0];
      q_cmd.recv_from = from_val[rss_pkg::IDX_W-1:0];
      q_cmd.tx_start  = to_val[rss_pkg::IDX_W-1:0];
      q_cmd.rx_start  = my_index_r;
      q_cmd.stride    = stride_val[rss_pkg::IDX_W-1:0];
      q_cmd.count     = count_val[rss_pkg::IDX_W-1:0];
      q_cmd.ranks     = n;
    end
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

endmodule

>>> rtl/rss_queue.sv
// two-entry command queue between front and back
module rss_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  rss_pkg::cmd_t push_cmd,
  input  logic          pop,
  output rss_pkg::cmd_t pop_cmd,
  output logic          full,
  output logic          empty
);

  rss_pkg::cmd_t slot_r [rss_pkg::QUEUE_DEPTH];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    fill_r, fill_nxt;

  assign full    = (fill_r == 2'(rss_pkg::QUEUE_DEPTH));
  assign empty   = (fill_r == 2'd0);
  assign pop_cmd = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = ~wr_ptr_r;
    end
    if (pop) begin
      rd_ptr_nxt = ~rd_ptr_r;
    end
    if (push && !pop) begin
      fill_nxt = fill_r + 2'd1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

>>> rtl/rss_back.sv
// back end: walks the slice pairs of one command, one result beat per cycle while out_stall is low
module rss_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_empty,
  input  rss_pkg::cmd_t               q_cmd,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [rss_pkg::IDX_W-1:0]   out_send_to,
  output logic [rss_pkg::IDX_W-1:0]   out_recv_from,
  output logic [rss_pkg::IDX_W-1:0]   out_tx_slice,
  output logic [rss_pkg::IDX_W-1:0]   out_rx_slice,
  output logic [rss_pkg::CNT_W-1:0]   out_rx_scratch_slice,
  output logic [1:0]                  out_status,
  output logic                        out_last
);

  logic                      busy_r, busy_nxt;
  rss_pkg::cmd_t             cmd_r;
  logic [rss_pkg::IDX_W-1:0] tx_cursor_r, rx_cursor_r;
  logic [rss_pkg::IDX_W-1:0] slices_left_r;

  logic                      out_valid_r, out_valid_nxt;
  logic [rss_pkg::IDX_W-1:0] send_to_r, recv_from_r, tx_slice_r, rx_slice_r;
  logic [rss_pkg::CNT_W-1:0] scratch_r;
  logic [1:0]                status_r;
  logic                      last_r;

  logic                      slot_free;
  logic                      emit;
  logic                      emit_last;
  logic [rss_pkg::CNT_W-1:0] tx_step, rx_step;

  assign slot_free = !out_valid_r || !out_stall;
  assign emit      = busy_r && slot_free;
  assign emit_last = emit && (slices_left_r == 7'd1);
  // load the next command when idle or on the final beat of the current one
  assign q_pop     = !q_empty && (!busy_r || emit_last);

  always_comb begin
    tx_step = ({1'b0, tx_cursor_r} >= {1'b0, cmd_r.stride})
              ? {1'b0, tx_cursor_r} - {1'b0, cmd_r.stride}
              : {1'b0, tx_cursor_r} + cmd_r.ranks - {1'b0, cmd_r.stride};
    rx_step = ({1'b0, rx_cursor_r} >= {1'b0, cmd_r.stride})
              ? {1'b0, rx_cursor_r} - {1'b0, cmd_r.stride}
              : {1'b0, rx_cursor_r} + cmd_r.ranks - {1'b0, cmd_r.stride};
    busy_nxt = busy_r;
    if (q_pop) begin
      busy_nxt = 1'b1;
    end else if (emit_last) begin
      busy_nxt = 1'b0;
    end
    out_valid_nxt = slot_free ? busy_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r         <= q_cmd;
      tx_cursor_r   <= q_cmd.tx_start;
      rx_cursor_r   <= q_cmd.rx_start;
      slices_left_r <= q_cmd.count;
    end else if (emit) begin
      tx_cursor_r   <= tx_step[rss_pkg::IDX_W-1:0];
      rx_cursor_r   <= rx_step[rss_pkg::IDX_W-1:0];
      slices_left_r <= slices_left_r - 7'd1;
    end
    if (emit) begin
      send_to_r   <= cmd_r.send_to;
      recv_from_r <= cmd_r.recv_from;
      tx_slice_r  <= tx_cursor_r;
      rx_slice_r  <= rx_cursor_r;
      scratch_r   <= {1'b0, rx_cursor_r} + cmd_r.ranks;
      status_r    <= cmd_r.status;
      last_r      <= (slices_left_r == 7'd1);
    end
  end

  assign out_valid            = out_valid_r;
  assign out_send_to          = send_to_r;
  assign out_recv_from        = recv_from_r;
  assign out_tx_slice         = tx_slice_r;
  assign out_rx_slice         = rx_slice_r;
  assign out_rx_scratch_slice = scratch_r;
  assign out_status           = status_r;
  assign out_last             = last_r;

endmodule

>>> rtl/reduce_scatter_step_schedule_top.sv
// reduce-scatter step schedule: top level
// path: a step beat passes the command queue, the walker's command register and the result register
// throughput: n = (N-1+2^s) >> (s+1) result beats per step, one per cycle from the
//   back-end slice walker while out_stall is low; an idle walker first loads a command
// a two-entry command queue lets the front accept steps while the walker runs
// reset: synchronous active-low; N = 1, my_index = 0, queue and walker empty
module reduce_scatter_step_schedule_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rss_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [rss_pkg::STEP_W-1:0]     in_step,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [rss_pkg::IDX_W-1:0]      out_send_to,
  output logic [rss_pkg::IDX_W-1:0]      out_recv_from,
  output logic [rss_pkg::IDX_W-1:0]      out_tx_slice,
  output logic [rss_pkg::IDX_W-1:0]      out_rx_slice,
  output logic [rss_pkg::CNT_W-1:0]      out_rx_scratch_slice,
  output logic [1:0]                     out_status,
  output logic                           out_last
);

  logic          q_full, q_empty, q_push, q_pop;
  rss_pkg::cmd_t push_cmd, pop_cmd;

  rss_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_step   (in_step),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  rss_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .pop_cmd  (pop_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  rss_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .q_empty              (q_empty),
    .q_cmd                (pop_cmd),
    .q_pop                (q_pop),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_send_to          (out_send_to),
    .out_recv_from        (out_recv_from),
    .out_tx_slice         (out_tx_slice),
    .out_rx_slice         (out_rx_slice),
    .out_rx_scratch_slice (out_rx_scratch_slice),
    .out_status           (out_status),
    .out_last             (out_last)
  );

endmodule

>>> rtl/rss_checker.sv
// port-level checker for the reduce-scatter step schedule, bound to the top level
module rss_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [rss_pkg::IDX_W-1:0]      out_send_to,
  input logic [rss_pkg::IDX_W-1:0]      out_recv_from,
  input logic [rss_pkg::IDX_W-1:0]      out_tx_slice,
  input logic [rss_pkg::IDX_W-1:0]      out_rx_slice,
  input logic [rss_pkg::CNT_W-1:0]      out_rx_scratch_slice,
  input logic [1:0]                     out_status,
  input logic                           out_last
);

  // reset empties the result register
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat valid right after reset");

  // a stalled result beat stays and holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_tx_slice)
      && $stable(out_rx_slice) && $stable(out_last))
    else $error("stalled result beat changed");

  // error beats are single and carry zero indices
  a_err_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != rss_pkg::ST_OK |->
      out_last && out_tx_slice == '0 && out_rx_slice == '0
      && out_rx_scratch_slice == '0 && out_send_to == '0 && out_recv_from == '0)
    else $error("error beat with nonzero fields");

  // scratch slice sits above the receive slice by the ring size
  a_scratch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == rss_pkg::ST_OK |->
      out_rx_scratch_slice > {1'b0, out_rx_slice})
    else $error("scratch slice not above receive slice");

endmodule

bind reduce_scatter_step_schedule_top rss_checker u_rss_checker (.*);

>>> dv/tb.sv
// testbench for the reduce-scatter step schedule block: directed and random steps vs a predictor
module tb;

  localparam logic [rss_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [rss_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned PHASES = 10;
  localparam int unsigned STEPS_PER_PHASE = 19;

  typedef struct packed {
    logic [rss_pkg::IDX_W-1:0] send_to;
    logic [rss_pkg::IDX_W-1:0] recv_from;
    logic [rss_pkg::IDX_W-1:0] tx_slice;
    logic [rss_pkg::IDX_W-1:0] rx_slice;
    logic [rss_pkg::CNT_W-1:0] scratch;
    logic [1:0]                status;
    logic                      last;
  } slice_beat_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [rss_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [rss_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [rss_pkg::STEP_W-1:0]     in_step = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [rss_pkg::IDX_W-1:0]      out_send_to;
  logic [rss_pkg::IDX_W-1:0]      out_recv_from;
  logic [rss_pkg::IDX_W-1:0]      out_tx_slice;
  logic [rss_pkg::IDX_W-1:0]      out_rx_slice;
  logic [rss_pkg::CNT_W-1:0]      out_rx_scratch_slice;
  logic [1:0]                     out_status;
  logic                           out_last;

  // shadow of the configuration registers
  logic [rss_pkg::CNT_W-1:0] ring_size = 8'd1;
  logic [rss_pkg::IDX_W-1:0] my_pos = '0;

  slice_beat_t pending_beats[$];
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  bit          calm = 1'b0;

  always #5 clk = ~clk;

  reduce_scatter_step_schedule_top dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_step              (in_step),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_send_to          (out_send_to),
    .out_recv_from        (out_recv_from),
    .out_tx_slice         (out_tx_slice),
    .out_rx_slice         (out_rx_slice),
    .out_rx_scratch_slice (out_rx_scratch_slice),
    .out_status           (out_status),
    .out_last             (out_last)
  );

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
    mismatches++;
  endtask

  // append one expected beat at the tail
  task automatic queue_beat(input slice_beat_t b);
    pending_beats.insert(pending_beats.size(), b);
  endtask

  // number of halving steps for a ring of n ranks, ceil(log2 n)
  function automatic int unsigned ring_steps(input int unsigned n);
    int unsigned k;
    k = 0;
    while (k < 8 && (1 << k) < n) k++;
    return k;
  endfunction

  // queue the schedule beats that one step produces under the current setting
  task automatic plan_step(input logic [rss_pkg::STEP_W-1:0] s);
    int unsigned n;
    int unsigned me;
    int unsigned delta;
    int unsigned to;
    int unsigned stride;
    int unsigned cnt;
    int unsigned txc;
    int unsigned rxc;
    slice_beat_t b;
    n = (32'(ring_size) > rss_pkg::MAX_RANKS) ? rss_pkg::MAX_RANKS : 32'(ring_size);
    me = 32'(my_pos);
    b = '0;
    b.last = 1'b1;
    if (me >= n) begin
      b.status = rss_pkg::ST_BAD_INDEX;
      queue_beat(b);
    end else if (s >= ring_steps(n)) begin
      b.status = rss_pkg::ST_BAD_STEP;
      queue_beat(b);
    end else begin
      delta = 1 << s;
      to = (me + n - delta) % n;
      b.send_to = rss_pkg::IDX_W'(to);
      b.recv_from = rss_pkg::IDX_W'((me + delta) % n);
      b.status = rss_pkg::ST_OK;
      stride = (2 << s) % n;
      cnt = ((n - 1 + delta) >> (s + 1)) & 32'h7f;
      txc = to;
      rxc = me;
      for (int unsigned k = 0; k < cnt && k < 64; k++) begin
        b.tx_slice = rss_pkg::IDX_W'(txc);
        b.rx_slice = rss_pkg::IDX_W'(rxc);
        b.scratch = rss_pkg::CNT_W'(rxc + n);
        b.last = (k == cnt - 1);
        queue_beat(b);
        txc = (txc + n - stride) % n;
        rxc = (rxc + n - stride) % n;
      end
    end
  endtask

  // one step beat; valid stays high into the next call unless a gap is drawn
  task automatic send_step(input logic [rss_pkg::STEP_W-1:0] s);
    if (!calm && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_step <= s;
    do @(posedge clk); while (in_stall);
    plan_step(s);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [rss_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rss_pkg::CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      rss_pkg::CFG_RANK_COUNT: ring_size = d;
      rss_pkg::CFG_MY_INDEX:   my_pos = d[rss_pkg::IDX_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_ring(input logic [rss_pkg::CFG_DATA_W-1:0] n,
                          input logic [rss_pkg::CFG_DATA_W-1:0] me);
    drain();
    write_reg(rss_pkg::CFG_RANK_COUNT, n);
    write_reg(rss_pkg::CFG_MY_INDEX, me);
  endtask

  // a one-rank ring has no valid step at all
  task automatic test_reset_defaults();
    send_step(3'd0);
    send_step(3'd7);
  endtask

  task automatic test_ring_extremes();
    set_ring(8'd128, 8'd0);
    for (int s = 0; s < 8; s++) send_step(s[rss_pkg::STEP_W-1:0]);
    set_ring(8'd128, 8'd127);
    send_step(3'd0);
    send_step(3'd6);
    // oversized ring folds to the largest one
    set_ring(8'd200, 8'd5);
    send_step(3'd3);
    set_ring(8'd2, 8'd1);
    send_step(3'd0);
    send_step(3'd1);
    // stride wraps to zero
    set_ring(8'd4, 8'd3);
    send_step(3'd1);
  endtask

  task automatic test_error_cases();
    set_ring(8'd0, 8'd0);
    send_step(3'd0);
    set_ring(8'd5, 8'd5);
    send_step(3'd5);
    set_ring(8'd5, 8'd4);
    for (int s = 0; s < 4; s++) send_step(s[rss_pkg::STEP_W-1:0]);
  endtask

  // spare indexes are dropped, the top data bit of my index is dropped
  task automatic test_register_map();
    set_ring(8'd7, 8'h82);
    write_reg(CFG_SPARE_A, 8'hff);
    write_reg(CFG_SPARE_B, 8'h00);
    send_step(3'd1);
  endtask

  task automatic test_random_schedules();
    logic [rss_pkg::CFG_DATA_W-1:0] rc;
    logic [rss_pkg::IDX_W-1:0]      me;
    int unsigned                    n;
    int unsigned                    nsteps;
    for (int p = 0; p < PHASES; p++) begin
      case ($urandom_range(9))
        0: rc = 8'd0;
        1: rc = 8'd1;
        2: rc = rss_pkg::CFG_DATA_W'($urandom_range(129, 255));
        3: rc = 8'd128;
        default: rc = rss_pkg::CFG_DATA_W'($urandom_range(2, 128));
      endcase
      n = (32'(rc) > rss_pkg::MAX_RANKS) ? rss_pkg::MAX_RANKS : 32'(rc);
      if (n != 0 && $urandom_range(9) != 0) me = rss_pkg::IDX_W'($urandom_range(0, n - 1));
      else me = rss_pkg::IDX_W'($urandom_range(0, 127));
      set_ring(rc, {1'($urandom_range(1)), me});
      calm = (p == 3);
      nsteps = ring_steps(n);
      for (int i = 0; i < STEPS_PER_PHASE; i++) begin
        if (nsteps != 0 && $urandom_range(99) < 85)
          send_step(rss_pkg::STEP_W'($urandom_range(0, nsteps - 1)));
        else send_step(rss_pkg::STEP_W'($urandom_range(0, 7)));
      end
    end
    calm = 1'b0;
  endtask

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 20);
  end

  always @(posedge clk) begin : check_beat
    slice_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_beats.size() == 0) begin
        flag_mismatch("beat with nothing expected, status", int'(out_status), 0);
      end else begin
        want = pending_beats.pop_front();
        if (out_send_to !== want.send_to)
          flag_mismatch("send_to", int'(out_send_to), int'(want.send_to));
        if (out_recv_from !== want.recv_from)
          flag_mismatch("recv_from", int'(out_recv_from), int'(want.recv_from));
        if (out_tx_slice !== want.tx_slice)
          flag_mismatch("tx_slice", int'(out_tx_slice), int'(want.tx_slice));
        if (out_rx_slice !== want.rx_slice)
          flag_mismatch("rx_slice", int'(out_rx_slice), int'(want.rx_slice));
        if (out_rx_scratch_slice !== want.scratch)
          flag_mismatch("rx_scratch_slice", int'(out_rx_scratch_slice), int'(want.scratch));
        if (out_status !== want.status)
          flag_mismatch("status", int'(out_status), int'(want.status));
        if (out_last !== want.last) flag_mismatch("last", int'(out_last), int'(want.last));
      end
    end
  end

  // no beat on any channel for too long means the block is hung
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_ring_extremes();
    test_error_cases();
    test_register_map();
    test_random_schedules();
    drain();
    if (pending_beats.size() != 0) flag_mismatch("beats never seen", 0, pending_beats.size());
    if (mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
